### src/ymrfc_pkg.sv
// ----------------------------------------------------------------------------
// ymrfc_pkg: shared types and constants for the YMODEM frame checker
// Beat types, control byte codes, session encoding and the CRC step.
// ----------------------------------------------------------------------------
package ymrfc_pkg;

  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_ABORT = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  localparam logic [7:0] B_SOH = 8'h01;
  localparam logic [7:0] B_STX = 8'h02;
  localparam logic [7:0] B_EOT = 8'h04;
  localparam logic [7:0] B_ACK = 8'h06;
  localparam logic [7:0] B_NAK = 8'h15;
  localparam logic [7:0] B_CAN = 8'h18;
  localparam logic [7:0] B_C   = 8'h43;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_LENGTH  = 3'd1;
  localparam logic [2:0] ST_HEADER  = 3'd2;
  localparam logic [2:0] ST_SEQ     = 3'd3;
  localparam logic [2:0] ST_CRC     = 3'd4;
  localparam logic [2:0] ST_ABORTED = 3'd5;
  localparam logic [2:0] ST_UNKNOWN = 3'd6;

  localparam logic [1:0] PH_NAME   = 2'd0;
  localparam logic [1:0] PH_BLANKS = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic [10:0] POS_MAX   = 11'd2047;
  localparam logic [10:0] LEN_SOH   = 11'd133;
  localparam logic [10:0] LEN_STX   = 11'd1029;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_MSB   = 16'h8000;
  localparam int          QDEPTH    = 4;
  localparam int          QAW       = $clog2(QDEPTH);

  typedef enum logic [4:0] {
    SS_IDLE     = 5'b00001,
    SS_WAIT_HDR = 5'b00010,
    SS_RECV     = 5'b00100,
    SS_COMPLETE = 5'b01000,
    SS_ABORTED  = 5'b10000
  } sess_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic        reply_valid;
    logic [7:0]  reply_byte;
    logic [2:0]  status;
    logic        run_last;
    logic [2:0]  link_state;
    logic [31:0] bytes_received;
    logic [31:0] file_size;
    logic [7:0]  retry_total;
  } out_t;

  // one queued record: one or two beats sharing a state snapshot
  typedef struct packed {
    logic        two;
    logic        v0;
    logic [7:0]  b0;
    logic [2:0]  s0;
    logic [7:0]  b1;
    logic [2:0]  s1;
    logic [2:0]  link;
    logic [31:0] bytes;
    logic [31:0] size;
    logic [7:0]  retries;
  } rec_t;

  typedef struct packed {
    logic valid;
    rec_t rec;
  } rec_push_t;

  function automatic logic [2:0] sess_code(sess_t s);
    logic [2:0] c;
    case (s)
      SS_IDLE:     c = 3'd0;
      SS_WAIT_HDR: c = 3'd1;
      SS_RECV:     c = 3'd2;
      SS_COMPLETE: c = 3'd3;
      SS_ABORTED:  c = 3'd4;
      default:     c = 3'd0;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) c = (c << 1) ^ CRC_POLY;
      else c = c << 1;
    end
    return c;
  endfunction

endpackage

### src/ymrfc_front.sv
// ----------------------------------------------------------------------------
// ymrfc_front: byte intake, CRC, size parse and frame judgement
// Takes one beat per cycle with accept high, pushes a result record when due.
// ----------------------------------------------------------------------------
module ymrfc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  ymrfc_pkg::in_t      item,
  output ymrfc_pkg::rec_push_t push_o
);
  import ymrfc_pkg::*;

  sess_t       sess_r, sess_nxt;
  logic [10:0] pos_r, pos_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [7:0]  cmp_r, cmp_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] tp_r, tp_nxt;
  logic [7:0]  exp_r, exp_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] size_r, size_nxt;
  logic [31:0] cand_r, cand_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [7:0]  retry_r, retry_nxt;
  logic        found_r, found_nxt;

  always_comb begin
    logic [7:0]  b, old;
    logic        digit, blank, emit;
    logic [35:0] v;
    logic [32:0] sum;
    logic [10:0] dlen;
    rec_t        r;
    sess_nxt = sess_r; pos_nxt = pos_r; kind_nxt = kind_r; seq_nxt = seq_r;
    cmp_nxt = cmp_r; crc_nxt = crc_r; tp_nxt = tp_r; exp_nxt = exp_r;
    acc_nxt = acc_r; size_nxt = size_r; cand_nxt = cand_r; ph_nxt = ph_r;
    retry_nxt = retry_r; found_nxt = found_r;
    b = item.frame_byte;
    old = tp_r[15:8];
    digit = (old >= 8'h30) && (old <= 8'h39);
    blank = (old == 8'h20) || ((old >= 8'h09) && (old <= 8'h0D));
    v = '0; sum = '0; dlen = '0;
    emit = 1'b0;
    r = '0;
    if (accept) begin
      case (item.opcode)
        OP_START: begin
          emit = 1'b1;
          sess_nxt = SS_WAIT_HDR; retry_nxt = '0; acc_nxt = '0;
          size_nxt = '0; exp_nxt = '0;
          r.v0 = 1'b1; r.b0 = B_C; r.s0 = ST_OK;
        end
        OP_ABORT: begin
          emit = 1'b1;
          sess_nxt = SS_ABORTED;
          r.two = 1'b1; r.v0 = 1'b1; r.b0 = B_CAN; r.s0 = ST_ABORTED;
          r.b1 = B_CAN; r.s1 = ST_ABORTED;
        end
        OP_BYTE: begin
          if (pos_r == 11'd0) kind_nxt = b;
          else if (pos_r == 11'd1) seq_nxt = b;
          else if (pos_r == 11'd2) cmp_nxt = b;
          else begin
            if (pos_r >= 11'd5) begin
              crc_nxt = crc_step(crc_r, old);
              case (ph_r)
                PH_NAME: if (old == 8'h00) ph_nxt = PH_BLANKS;
                PH_BLANKS: begin
                  if (digit) begin
                    cand_nxt = {28'h0, old[3:0]};
                    found_nxt = 1'b1;
                    ph_nxt = PH_DIGITS;
                  end else if (!blank) ph_nxt = PH_DONE;
                end
                PH_DIGITS: begin
                  if (digit) begin
                    v = ({4'b0000, cand_r} << 3) + ({4'b0000, cand_r} << 1)
                        + {32'h0, old[3:0]};
                    cand_nxt = (v[35:32] != 4'b0000) ? 32'hFFFF_FFFF : v[31:0];
                  end else ph_nxt = PH_DONE;
                end
                default: ;
              endcase
            end
            tp_nxt = {tp_r[7:0], b};
          end
          if (pos_r < POS_MAX) pos_nxt = pos_r + 11'd1;

          if (item.frame_end) begin
            emit = 1'b1;
            r.v0 = 1'b1; r.b0 = B_NAK;
            if (kind_nxt == B_EOT) begin
              sess_nxt = SS_COMPLETE; r.b0 = B_ACK; r.s0 = ST_OK;
            end else if (kind_nxt == B_CAN) begin
              sess_nxt = SS_ABORTED; r.v0 = 1'b0; r.b0 = 8'h00; r.s0 = ST_ABORTED;
            end else if (kind_nxt != B_SOH && kind_nxt != B_STX) begin
              r.s0 = ST_HEADER;
            end else if (pos_nxt != ((kind_nxt == B_SOH) ? LEN_SOH : LEN_STX)) begin
              r.s0 = ST_LENGTH;
            end else if (seq_nxt != ~cmp_nxt) begin
              r.s0 = ST_SEQ;
            end else if (tp_nxt != crc_nxt) begin
              retry_nxt = retry_r + 8'd1; r.s0 = ST_CRC;
            end else if (seq_nxt == 8'd0 && sess_r == SS_WAIT_HDR) begin
              if (found_nxt) size_nxt = cand_nxt;
              acc_nxt = '0; exp_nxt = 8'd1; sess_nxt = SS_RECV;
              r.b0 = B_ACK; r.s0 = ST_OK;
              r.two = 1'b1; r.b1 = B_C; r.s1 = ST_OK;
            end else if (seq_nxt != 8'd0 && sess_r == SS_RECV) begin
              if (seq_nxt != exp_r) begin
                if (seq_nxt == exp_r - 8'd1) begin
                  r.b0 = B_ACK; r.s0 = ST_OK;
                end else r.s0 = ST_SEQ;
              end else begin
                dlen = (kind_nxt == B_SOH) ? 11'd128 : 11'd1024;
                sum = {1'b0, acc_r} + {22'h0, dlen};
                acc_nxt = (sum > {1'b0, size_r}) ? size_r : sum[31:0];
                exp_nxt = exp_r + 8'd1;
                r.b0 = B_ACK; r.s0 = ST_OK;
              end
            end else begin
              r.v0 = 1'b0; r.b0 = 8'h00; r.s0 = ST_UNKNOWN;
            end
          end
        end
        default: ;
      endcase
      if (item.opcode == OP_START || item.opcode == OP_ABORT ||
          (item.opcode == OP_BYTE && item.frame_end)) begin
        pos_nxt = '0; kind_nxt = '0; seq_nxt = '0; cmp_nxt = '0; crc_nxt = '0;
        tp_nxt = '0; cand_nxt = '0; ph_nxt = PH_NAME; found_nxt = 1'b0;
      end
    end
    r.link = sess_code(sess_nxt);
    r.bytes = acc_nxt;
    r.size = size_nxt;
    r.retries = retry_nxt;
    push_o.valid = emit;
    push_o.rec = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sess_r <= SS_IDLE; pos_r <= '0; kind_r <= '0; seq_r <= '0; cmp_r <= '0;
      crc_r <= '0; tp_r <= '0; exp_r <= '0; acc_r <= '0; size_r <= '0;
      cand_r <= '0; ph_r <= PH_NAME; retry_r <= '0; found_r <= 1'b0;
    end else begin
      sess_r <= sess_nxt; pos_r <= pos_nxt; kind_r <= kind_nxt; seq_r <= seq_nxt;
      cmp_r <= cmp_nxt; crc_r <= crc_nxt; tp_r <= tp_nxt; exp_r <= exp_nxt;
      acc_r <= acc_nxt; size_r <= size_nxt; cand_r <= cand_nxt; ph_r <= ph_nxt;
      retry_r <= retry_nxt; found_r <= found_nxt;
    end
  end

  a_start_waits: assert property (@(posedge clk) disable iff (!rst_n)
    accept && item.opcode == OP_START |=> sess_r == SS_WAIT_HDR)
    else $error("start did not enter wait header");

endmodule

### src/ymrfc_back.sv
// ----------------------------------------------------------------------------
// ymrfc_back: record queue and beat expansion
// Holds up to four records and issues one or two result beats per record.
// ----------------------------------------------------------------------------
module ymrfc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ymrfc_pkg::rec_push_t push_i,
  output logic                 full_o,
  output logic                 empty,
  input  logic                 pop,
  output ymrfc_pkg::out_t      out_data
);
  import ymrfc_pkg::*;

  rec_t           q_r [QDEPTH];
  logic [QAW-1:0] wr_r, rd_r;
  logic [QAW:0]   cnt_r;
  logic           beat_r;
  rec_t           head;
  logic           take, last;

  assign head   = q_r[rd_r];
  assign empty  = (cnt_r == '0);
  assign full_o = (cnt_r == (QAW+1)'(QDEPTH));
  assign last   = beat_r || !head.two;
  assign take   = pop && !empty;

  always_comb begin
    out_data.reply_valid    = beat_r ? 1'b1 : head.v0;
    out_data.reply_byte     = beat_r ? head.b1 : head.b0;
    out_data.status         = beat_r ? head.s1 : head.s0;
    out_data.run_last       = last;
    out_data.link_state     = head.link;
    out_data.bytes_received = head.bytes;
    out_data.file_size      = head.size;
    out_data.retry_total    = head.retries;
  end

  always_ff @(posedge clk) begin
    if (push_i.valid) q_r[wr_r] <= push_i.rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0; rd_r <= '0; cnt_r <= '0; beat_r <= 1'b0;
    end else begin
      if (push_i.valid) wr_r <= wr_r + 1'b1;
      if (take && last) rd_r <= rd_r + 1'b1;
      if (take) beat_r <= !last;
      cnt_r <= cnt_r + (QAW+1)'(push_i.valid) - (QAW+1)'(take && last);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_i.valid && full_o))
    else $error("push into full record queue");
  a_second_beat: assert property (@(posedge clk) disable iff (!rst_n)
    beat_r |-> !empty && head.two)
    else $error("second beat without a two-beat record");
  a_beat_holds: assert property (@(posedge clk) disable iff (!rst_n)
    beat_r && !pop |=> beat_r)
    else $error("second beat lost while stalled");

endmodule

### src/ymodem_receiver_frame_checker_unit.sv
// ----------------------------------------------------------------------------
// ymodem_receiver_frame_checker_unit: YMODEM receive-side frame checker
// Judges received frames (CRC-16/XMODEM) and produces control replies.
// ----------------------------------------------------------------------------
// Push one beat per cycle: a frame byte (with frame_end on the last one), a
// start command or an abort command. Every payload byte passes a two-byte hold
// register into the CRC and the file size parser, so input beats are accepted
// back to back, one per clock, while full is low. A beat that closes a frame,
// and every start or abort, queues one record in a four-deep queue; the
// result side pops one result beat per cycle with pop high, one per record or
// two for an accepted header (ACK, C) and an abort (CAN, CAN). run_last marks the final
// result of a given input. full rises when four records wait unread: a stall
// on the result side fills the queue, and so can a dense run of two-beat
// records (aborts back to back), which drain at half the input rate.
// The first result of a push is registered in the record queue before the ports.
module ymodem_receiver_frame_checker_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  ymrfc_pkg::in_t    in_data,
  output logic              empty,
  input  logic              pop,
  output ymrfc_pkg::out_t   out_data
);
  import ymrfc_pkg::*;

  rec_push_t rec_push;
  logic      accept;

  // front sees only beats the queue has room for
  assign accept = push && !full;

  ymrfc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .push_o (rec_push)
  );

  ymrfc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_i   (rec_push),
    .full_o   (full),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule
